### rtl/prc_pkg.sv
// prc_pkg: shared widths, types and the factorial table for the permutation rank unit
// no dependencies; used by every module under rtl
package prc_pkg;

   localparam int SLOTS           = 12;   // elements held by one input item
   localparam int ELEM_W          = 4;
   localparam int LEN_W           = 4;
   localparam int PACKED_W        = SLOTS * ELEM_W;
   localparam int RANK_W          = 29;
   localparam int MASK_W          = 1 << ELEM_W;
   localparam int GROUP_SIZE      = 3;    // products summed per adder group
   localparam int MAX_LEN_DEFAULT = 12;

   localparam logic [LEN_W-1:0]  LEN_RESET  = 4'd12;
   localparam logic [RANK_W-1:0] RANK_LIMIT = 29'd479001600;   // 12!

   typedef logic [ELEM_W-1:0]            elem_type;
   typedef elem_type [SLOTS-1:0]         elem_vec_type;
   typedef logic [RANK_W-1:0]            rank_type;
   typedef rank_type [SLOTS-1:0]         rank_vec_type;

   typedef struct packed {
      logic             valid;
      logic             bad;
      logic [LEN_W-1:0] len;
   } stage_ctl_type;

   function automatic rank_type fact_of(input logic [LEN_W-1:0] k);
      rank_type f;
      case (k)
         4'd0:    f = 29'd1;
         4'd1:    f = 29'd1;
         4'd2:    f = 29'd2;
         4'd3:    f = 29'd6;
         4'd4:    f = 29'd24;
         4'd5:    f = 29'd120;
         4'd6:    f = 29'd720;
         4'd7:    f = 29'd5040;
         4'd8:    f = 29'd40320;
         4'd9:    f = 29'd362880;
         4'd10:   f = 29'd3628800;
         4'd11:   f = 29'd39916800;
         4'd12:   f = 29'd479001600;
         default: f = 29'd0;
      endcase
      return f;
   endfunction

endpackage

### rtl/permutation_rank_unit.sv
// permutation_rank_unit: lexicographic (lehmer code) rank of a packed permutation
// path: input register, then the lehmer, weight, adder-group and result registers in order
// throughput: one item per cycle; five register stages advance together and
//   hold as a whole only while the result register is full and not taken
// reset: synchronous, clears all valid bits and sets the length register to 12
// depends on prc_pkg, prc_lehmer, prc_weight, prc_sum
module permutation_rank_unit #(
   parameter int MAX_LEN = prc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [prc_pkg::PACKED_W-1:0] req_perm_packed,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [prc_pkg::RANK_W-1:0]   rsp_rank,
   output logic                         rsp_not_permutation,
   input  logic                         csr_wr_en,
   input  logic [prc_pkg::LEN_W-1:0]    csr_wr_data
);

   localparam int LEN_CAP = (MAX_LEN < prc_pkg::SLOTS) ? MAX_LEN : prc_pkg::SLOTS;
   localparam logic [prc_pkg::LEN_W-1:0] LEN_CAP_L = prc_pkg::LEN_W'(LEN_CAP);

   logic [prc_pkg::LEN_W-1:0] csr_perm_length_ff;
   logic [prc_pkg::LEN_W-1:0] eff_len;
   logic                      adv;
   prc_pkg::stage_ctl_type    s1_ctl_in;
   prc_pkg::stage_ctl_type    s1_ctl_ff;
   prc_pkg::elem_vec_type     s1_elem_ff;
   prc_pkg::stage_ctl_type    s2_ctl;
   prc_pkg::elem_vec_type     s2_digit;
   prc_pkg::stage_ctl_type    s3_ctl;
   prc_pkg::rank_vec_type     s3_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_perm_length_ff <= prc_pkg::LEN_RESET;
      end else if (csr_wr_en) begin
         csr_perm_length_ff <= csr_wr_data;
      end
   end

   assign eff_len = (csr_perm_length_ff > LEN_CAP_L) ? LEN_CAP_L : csr_perm_length_ff;

   // whole pipe moves unless the result register holds an item not yet taken
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   assign s1_ctl_in.valid = req_valid;
   assign s1_ctl_in.bad   = 1'b0;
   assign s1_ctl_in.len   = eff_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (adv) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_elem_ff <= req_perm_packed;
      end
   end

   prc_lehmer u_lehmer (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_ctl    (s1_ctl_ff),
      .in_elem   (s1_elem_ff),
      .out_ctl   (s2_ctl),
      .out_digit (s2_digit)
   );

   prc_weight u_weight (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_ctl   (s2_ctl),
      .in_digit (s2_digit),
      .out_ctl  (s3_ctl),
      .out_prod (s3_prod)
   );

   prc_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_ctl    (s3_ctl),
      .in_prod   (s3_prod),
      .out_valid (rsp_valid),
      .out_bad   (rsp_not_permutation),
      .out_rank  (rsp_rank)
   );

   // a valid permutation never ranks at or beyond 12!
   a_rank_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_not_permutation |-> rsp_rank < prc_pkg::RANK_LIMIT)
      else $error("rank out of range");

   // a flagged item carries a zero rank
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_permutation |-> rsp_rank == '0)
      else $error("flagged item with non-zero rank");

   // while stalled, no stage gains or drops an item
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable({s1_ctl_ff.valid, s2_ctl.valid, s3_ctl.valid}) && rsp_valid)
      else $error("pipeline valid bits changed during stall");

   // an empty result register always leaves the input open
   a_ready_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

endmodule

### rtl/prc_lehmer.sv
// prc_lehmer: lehmer digits and permutation check, one register stage
// depends on prc_pkg
module prc_lehmer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  prc_pkg::stage_ctl_type in_ctl,
   input  prc_pkg::elem_vec_type  in_elem,
   output prc_pkg::stage_ctl_type out_ctl,
   output prc_pkg::elem_vec_type  out_digit
);

   logic [prc_pkg::SLOTS-1:0][prc_pkg::SLOTS-1:0] less_mat;
   logic [prc_pkg::MASK_W-1:0] seen_mask;
   logic [prc_pkg::MASK_W-1:0] full_mask;
   logic                       bad_in;
   prc_pkg::elem_vec_type      digit_in;
   prc_pkg::elem_vec_type      digit_ff;
   prc_pkg::stage_ctl_type     ctl_ff;

   // less_mat[p][q]: an earlier element q is smaller than element p
   always_comb begin
      less_mat = '0;
      for (int p = 0; p < prc_pkg::SLOTS; p++) begin
         for (int q = 0; q < p; q++) begin
            less_mat[p][q] = in_elem[q] < in_elem[p];
         end
      end
   end

   assign full_mask = (prc_pkg::MASK_W'(1) << in_ctl.len) - prc_pkg::MASK_W'(1);

   always_comb begin
      seen_mask = '0;
      bad_in    = in_ctl.bad;
      for (int p = 0; p < prc_pkg::SLOTS; p++) begin
         if (prc_pkg::LEN_W'(p) < in_ctl.len) begin
            digit_in[p] = in_elem[p] - prc_pkg::ELEM_W'($countones(less_mat[p]));
            seen_mask   = seen_mask | (prc_pkg::MASK_W'(1) << in_elem[p]);
            if (prc_pkg::LEN_W'(in_elem[p]) >= in_ctl.len) begin
               bad_in = 1'b1;
            end
         end else begin
            digit_in[p] = '0;
         end
      end
      // in range and covering every value means no repeats
      if (seen_mask != full_mask) begin
         bad_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff.valid <= in_ctl.valid;
         ctl_ff.bad   <= bad_in;
         ctl_ff.len   <= in_ctl.len;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         digit_ff <= digit_in;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_digit = digit_ff;

endmodule

### rtl/prc_weight.sv
// prc_weight: multiplies each lehmer digit by its factorial weight, one register stage
// depends on prc_pkg
module prc_weight (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  prc_pkg::stage_ctl_type in_ctl,
   input  prc_pkg::elem_vec_type  in_digit,
   output prc_pkg::stage_ctl_type out_ctl,
   output prc_pkg::rank_vec_type  out_prod
);

   localparam int PROD_W = prc_pkg::RANK_W + prc_pkg::ELEM_W;

   logic [prc_pkg::SLOTS-1:0][prc_pkg::LEN_W-1:0] weight_idx;
   logic [prc_pkg::SLOTS-1:0][PROD_W-1:0]         prod_full;
   prc_pkg::rank_vec_type                         prod_in;
   prc_pkg::rank_vec_type                         prod_ff;
   prc_pkg::stage_ctl_type                        ctl_ff;

   always_comb begin
      for (int p = 0; p < prc_pkg::SLOTS; p++) begin
         weight_idx[p] = in_ctl.len - prc_pkg::LEN_W'(p) - prc_pkg::LEN_W'(1);
         prod_full[p]  = PROD_W'(in_digit[p]) * PROD_W'(prc_pkg::fact_of(weight_idx[p]));
         // positions past the length carry no weight
         prod_in[p]    = (prc_pkg::LEN_W'(p) < in_ctl.len) ?
                         prod_full[p][prc_pkg::RANK_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_prod = prod_ff;

endmodule

### rtl/prc_sum.sv
// prc_sum: two-stage adder tree over the weighted digits and the result register
// depends on prc_pkg
module prc_sum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  prc_pkg::stage_ctl_type in_ctl,
   input  prc_pkg::rank_vec_type  in_prod,
   output logic                   out_valid,
   output logic                   out_bad,
   output prc_pkg::rank_type      out_rank
);

   localparam int GROUPS = (prc_pkg::SLOTS + prc_pkg::GROUP_SIZE - 1) / prc_pkg::GROUP_SIZE;

   prc_pkg::rank_type [GROUPS-1:0] group_in;
   prc_pkg::rank_type [GROUPS-1:0] group_ff;
   prc_pkg::stage_ctl_type         ctl_ff;
   prc_pkg::rank_type              total_in;
   prc_pkg::rank_type              rank_ff;
   logic                           valid_ff;
   logic                           bad_ff;

   always_comb begin
      group_in = '0;
      for (int p = 0; p < prc_pkg::SLOTS; p++) begin
         group_in[p / prc_pkg::GROUP_SIZE] = group_in[p / prc_pkg::GROUP_SIZE] + in_prod[p];
      end
   end

   always_comb begin
      total_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total_in = total_in + group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '0;
         valid_ff <= 1'b0;
         bad_ff   <= 1'b0;
      end else if (adv) begin
         ctl_ff   <= in_ctl;
         valid_ff <= ctl_ff.valid;
         bad_ff   <= ctl_ff.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         group_ff <= group_in;
         rank_ff  <= ctl_ff.bad ? '0 : total_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_bad   = bad_ff;
   assign out_rank  = rank_ff;

endmodule
